// ===== src/snlf_pkg.sv =====
// shared constants and controller/datapath interface types for the skyline filter
`default_nettype none

package snlf_pkg;

    localparam int MAX_TUPLES_DEF = 64;
    localparam int COORD_BITS_DEF = 32;
    localparam int MAX_DIMS       = 4;
    localparam int NUM_COORDS     = 4;
    localparam int CFG_W          = 3;
    localparam int OUT_W          = 32;
    localparam int POS_W          = 6;

    localparam logic [CFG_W-1:0] DIMS_RESET = CFG_W'(MAX_DIMS);

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic cand_rd;
        logic cand_ld;
        logic scan_rd;
        logic keep;
        logic next_i;
        logic flush;
    } t_cmd;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic j_last;
        logic i_last;
        logic dom;
        logic pend_vld;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/skyline_nested_loop_filter_core.sv =====
// top level of the skyline filter: sequencer plus tuple store datapath
// non-final tuples are taken one tuple per cycle, back to back
// final tuple: the input stalls through the compare phase plus any output stall; each candidate
//   costs a read, a latch, a scan read per stored tuple, a wait state and a decide state
//   on the single read port of the tuple ram
// results leave through one output register, the last one marked run_end
// reset (synchronous, active low) empties the set, clears the overflow flag, active_dims to 4;
//   ram contents are not cleared, only entries below the fill count are ever read
`default_nettype none

module skyline_nested_loop_filter_core #(
    parameter int MAX_TUPLES = snlf_pkg::MAX_TUPLES_DEF,
    parameter int COORD_BITS = snlf_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration: active_dims
    input  wire logic                              i_cfg_we,
    input  wire logic [snlf_pkg::CFG_W-1:0]        i_cfg_data,
    // input tuple requests
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_a,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_b,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_c,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_d,
    input  wire logic                              i_final_tuple,
    // skyline result requests
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [snlf_pkg::OUT_W-1:0]      o_out_a,
    output logic signed [snlf_pkg::OUT_W-1:0]      o_out_b,
    output logic signed [snlf_pkg::OUT_W-1:0]      o_out_c,
    output logic signed [snlf_pkg::OUT_W-1:0]      o_out_d,
    output logic        [snlf_pkg::POS_W-1:0]      o_tuple_position,
    output logic                                   o_run_end,
    output logic                                   o_dropped_flag
);
    import snlf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: load while idle, then per candidate read it, scan all stored tuples,
    // decide, and hand kept tuples through a one-deep pending slot so the last one
    // can be tagged with run_end
    snlf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_final_tuple (i_final_tuple),
        .o_stall       (o_stall),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    // datapath: store, counters, per-dimension compares and output register
    snlf_dp #(
        .MAX_TUPLES (MAX_TUPLES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_coord_a        (i_coord_a),
        .i_coord_b        (i_coord_b),
        .i_coord_c        (i_coord_c),
        .i_coord_d        (i_coord_d),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_out_a          (o_out_a),
        .o_out_b          (o_out_b),
        .o_out_c          (o_out_c),
        .o_out_d          (o_out_d),
        .o_tuple_position (o_tuple_position),
        .o_run_end        (o_run_end),
        .o_dropped_flag   (o_dropped_flag)
    );

endmodule

`default_nettype wire

// ===== src/snlf_ram.sv =====
// generic single write port ram with one registered read port
`default_nettype none

module snlf_ram #(
    parameter int W     = 128,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/snlf_ctrl.sv =====
// sequencer for loading, pairwise dominance scan and result emission
`default_nettype none

module snlf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_final_tuple,
    output logic               o_stall,
    output snlf_pkg::t_cmd     o_cmd,
    input  wire snlf_pkg::t_sts i_sts
);
    import snlf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CLD,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_final_tuple) begin
                        n_state = S_CRD;
                    end
                end
            end
            S_CRD: begin
                o_cmd.cand_rd = 1'b1;
                n_state       = S_CLD;
            end
            S_CLD: begin
                o_cmd.cand_ld = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.dom || !i_sts.pend_vld || i_sts.out_free) begin
                    o_cmd.keep = !i_sts.dom;
                    if (i_sts.i_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.next_i = 1'b1;
                        n_state      = S_CRD;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/snlf_dp.sv =====
// tuple store, counters, dominance compare, pending and output registers
`default_nettype none

module snlf_dp #(
    parameter int MAX_TUPLES = snlf_pkg::MAX_TUPLES_DEF,
    parameter int COORD_BITS = snlf_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire snlf_pkg::t_cmd                i_cmd,
    output snlf_pkg::t_sts                     o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [snlf_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_a,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_b,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_c,
    input  wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_d,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic signed [snlf_pkg::OUT_W-1:0]  o_out_a,
    output logic signed [snlf_pkg::OUT_W-1:0]  o_out_b,
    output logic signed [snlf_pkg::OUT_W-1:0]  o_out_c,
    output logic signed [snlf_pkg::OUT_W-1:0]  o_out_d,
    output logic        [snlf_pkg::POS_W-1:0]  o_tuple_position,
    output logic                               o_run_end,
    output logic                               o_dropped_flag
);
    import snlf_pkg::*;

    localparam int AW = $clog2(MAX_TUPLES);
    localparam int CW = $clog2(MAX_TUPLES + 1);
    localparam int RW = NUM_COORDS * COORD_BITS;

    typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] t_tuple;

    logic [CFG_W-1:0] r_dims;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [AW-1:0]    r_i;
    logic [AW-1:0]    r_j;
    logic             r_dom;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    logic             r_pend_vld;
    logic             r_out_vld;

    t_tuple           r_cand;
    t_tuple           r_pend;
    logic [AW-1:0]    r_pend_pos;
    t_tuple           r_out_tuple;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_end;
    logic             r_out_drop;

    logic             full;
    logic             wr_en;
    logic [AW-1:0]    raddr;
    logic [RW-1:0]    wdata;
    logic [RW-1:0]    rdata;
    t_tuple           rd_tuple;
    logic [CFG_W-1:0] dims_used;
    logic [NUM_COORDS-1:0] act;
    logic [NUM_COORDS-1:0] le_d;
    logic [NUM_COORDS-1:0] lt_d;
    logic             beats;
    logic             out_free;
    logic             push;

    assign full  = (r_count >= CW'(MAX_TUPLES));
    assign wr_en = i_cmd.load && !full;
    assign raddr = i_cmd.cand_rd ? r_i : r_j;
    assign wdata = {i_coord_d[COORD_BITS-1:0], i_coord_c[COORD_BITS-1:0],
                    i_coord_b[COORD_BITS-1:0], i_coord_a[COORD_BITS-1:0]};

    snlf_ram #(
        .W     (RW),
        .DEPTH (MAX_TUPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_tuple = t_tuple'(rdata);

    // zero acts as one dimension, large values clamp
    always_comb begin
        if (r_dims == '0) begin
            dims_used = CFG_W'(1);
        end else if (r_dims > CFG_W'(MAX_DIMS)) begin
            dims_used = CFG_W'(MAX_DIMS);
        end else begin
            dims_used = r_dims;
        end
    end

    // streamed tuple j against held candidate i
    always_comb begin
        for (int d = 0; d < NUM_COORDS; d++) begin
            act[d]  = (CFG_W'(d) < dims_used);
            le_d[d] = ($signed(rd_tuple[d]) <= $signed(r_cand[d]));
            lt_d[d] = ($signed(rd_tuple[d]) <  $signed(r_cand[d]));
        end
        beats = (&(~act | le_d)) && (|(act & lt_d));
    end

    assign out_free = !r_out_vld || !i_stall;
    assign push     = (i_cmd.keep && r_pend_vld) || i_cmd.flush;

    assign o_sts.j_last   = (CW'(r_j) == (r_count - CW'(1)));
    assign o_sts.i_last   = (CW'(r_i) == (r_count - CW'(1)));
    assign o_sts.dom      = r_dom;
    assign o_sts.pend_vld = r_pend_vld;
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims     <= DIMS_RESET;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_dom      <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dims <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.flush) begin
                r_count    <= '0;
                r_ovf      <= 1'b0;
                r_i        <= '0;
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.next_i) begin
                r_i <= r_i + AW'(1);
            end
            if (i_cmd.cand_ld) begin
                r_j <= '0;
            end else if (i_cmd.scan_rd) begin
                r_j <= r_j + AW'(1);
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.cand_ld) begin
                r_dom <= 1'b0;
            end else if (r_rd_vld && (r_rd_idx != r_i) && beats) begin
                r_dom <= 1'b1;
            end
            if (i_cmd.keep) begin
                r_pend_vld <= 1'b1;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_j;
        if (i_cmd.cand_ld) begin
            r_cand <= rd_tuple;
        end
        if (i_cmd.keep) begin
            r_pend     <= r_cand;
            r_pend_pos <= r_i;
        end
        if (push) begin
            r_out_tuple <= r_pend;
            r_out_pos   <= POS_W'(r_pend_pos);
            r_out_end   <= i_cmd.flush;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_out_a          = OUT_W'($signed(r_out_tuple[0]));
    assign o_out_b          = OUT_W'($signed(r_out_tuple[1]));
    assign o_out_c          = OUT_W'($signed(r_out_tuple[2]));
    assign o_out_d          = OUT_W'($signed(r_out_tuple[3]));
    assign o_tuple_position = r_out_pos;
    assign o_run_end        = r_out_end;
    assign o_dropped_flag   = r_out_drop;

endmodule

`default_nettype wire

// ===== src/snlf_checker.sv =====
// port-level checks of the skyline filter and their bind to the top level
`default_nettype none

module snlf_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_cfg_we,
    input wire logic [snlf_pkg::CFG_W-1:0]        i_cfg_data,
    input wire logic                              i_valid,
    input wire logic                              o_stall,
    input wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_a,
    input wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_b,
    input wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_c,
    input wire logic signed [snlf_pkg::OUT_W-1:0] i_coord_d,
    input wire logic                              i_final_tuple,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic signed [snlf_pkg::OUT_W-1:0] o_out_a,
    input wire logic signed [snlf_pkg::OUT_W-1:0] o_out_b,
    input wire logic signed [snlf_pkg::OUT_W-1:0] o_out_c,
    input wire logic signed [snlf_pkg::OUT_W-1:0] o_out_d,
    input wire logic        [snlf_pkg::POS_W-1:0] o_tuple_position,
    input wire logic                              o_run_end,
    input wire logic                              o_dropped_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_a) && $stable(o_out_b)
            && $stable(o_out_c) && $stable(o_out_d) && $stable(o_tuple_position)
            && $stable(o_run_end) && $stable(o_dropped_flag))
        else $error("stalled result changed");

    // a final tuple starts the compare phase
    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_final_tuple |=> o_stall)
        else $error("no stall after final tuple");

    // ordinary tuples load back to back
    a_load_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_final_tuple |=> !o_stall)
        else $error("stall after non-final tuple");

    // leaving the compare phase coincides with the run_end result
    a_end_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid && o_run_end)
        else $error("compare phase ended without run_end result");

endmodule

bind skyline_nested_loop_filter_core snlf_checker u_snlf_checker (.*);

`default_nettype wire
